[src/tqp_pkg.sv]
// Shared types, constants and the quarter-step decode table for the quadrature position block.
`default_nettype none
package tqp_pkg;

   localparam int unsigned LimitWidth = 7;
   localparam int unsigned PosWidth = 8;
   localparam logic [LimitWidth-1:0] LimitReset = 7'd100;
   localparam logic signed [2:0] StepFull = 3'sd2;

   typedef logic signed [1:0] step_type;

   typedef struct packed {
      logic signed [PosWidth-1:0] x_position;
      logic signed [PosWidth-1:0] y_position;
   } tqp_result_type;

   function automatic step_type tqp_quarter_step(input logic [3:0] idx);
      step_type step;
      case (idx)
         4'h1, 4'h7, 4'h8, 4'hE: step = -2'sd1;
         4'h2, 4'h4, 4'hB, 4'hD: step = 2'sd1;
         default: step = 2'sd0;
      endcase
      return step;
   endfunction

endpackage
`default_nettype wire

[src/two_axis_quadrature_position.sv]
// Two-axis x4 quadrature position decoder, top level.
//
// Input channel req_*: one transaction carries the sampled A and B levels of
// the X and Y encoders. Each axis lane decodes the previous and present phase
// into a quarter-step, accumulates two quarter-steps into one count, and clamps
// the position to +/- the limit register.
// Result channel rsp_*: one transaction per input with both positions, two's
// complement. A result is registered in the output register, or in the skid
// stage when the output stalls. Throughput is one transaction per cycle; both
// lanes update in the accepting cycle, and the output register plus a one-entry
// skid stage let a new input enter while a result waits. req_ready drops only
// when both are full, i.e. after the receiver has stalled for two results.
// csr_write_enable/csr_write_data write the 7-bit position limit; write it only
// while no transaction is in flight.
// Reset clears phases, sub-counts and positions to zero, sets the limit to 100
// and empties the output stages.
`default_nettype none
module two_axis_quadrature_position
   import tqp_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic                   req_x_phase_a,
   input  wire logic                   req_x_phase_b,
   input  wire logic                   req_y_phase_a,
   input  wire logic                   req_y_phase_b,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic signed [PosWidth-1:0]  rsp_x_position,
   output logic signed [PosWidth-1:0]  rsp_y_position,
   input  wire logic                   csr_write_enable,
   input  wire logic [LimitWidth-1:0]  csr_write_data
);

   logic [LimitWidth-1:0]      limit_ff;
   logic                       accept;
   logic signed [PosWidth-1:0] x_lane_position;
   logic signed [PosWidth-1:0] y_lane_position;
   tqp_result_type             lane_result;
   tqp_result_type             out_result;

   assign accept = req_valid & req_ready;
   assign lane_result = {x_lane_position, y_lane_position};

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LimitReset;
      end else if (csr_write_enable) begin
         limit_ff <= csr_write_data;
      end
   end

   tqp_axis u_x_axis (
      .clock    (clock),
      .reset    (reset),
      .advance  (accept),
      .phase_a  (req_x_phase_a),
      .phase_b  (req_x_phase_b),
      .limit    (limit_ff),
      .position (x_lane_position)
   );

   tqp_axis u_y_axis (
      .clock    (clock),
      .reset    (reset),
      .advance  (accept),
      .phase_a  (req_y_phase_a),
      .phase_b  (req_y_phase_b),
      .limit    (limit_ff),
      .position (y_lane_position)
   );

   tqp_out u_out (
      .clock      (clock),
      .reset      (reset),
      .push       (accept),
      .push_data  (lane_result),
      .push_ready (req_ready),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_data   (out_result)
   );

   assign rsp_x_position = out_result.x_position;
   assign rsp_y_position = out_result.y_position;

endmodule
`default_nettype wire

[src/tqp_axis.sv]
// One axis lane: phase decode, sub-count and saturating position counter.
`default_nettype none
module tqp_axis
   import tqp_pkg::*;
(
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         advance,
   input  wire logic                         phase_a,
   input  wire logic                         phase_b,
   input  wire logic [LimitWidth-1:0]        limit,
   output logic signed [PosWidth-1:0]        position
);

   logic [1:0]                 last_ff, last_in;
   logic signed [1:0]          sub_ff, sub_in;
   logic signed [PosWidth-1:0] count_ff, count_in;

   logic [1:0]                 now_phase;
   step_type                   step;
   logic signed [2:0]          sub_sum;
   logic signed [2:0]          sub_adj;
   logic signed [PosWidth:0]   delta;
   logic signed [PosWidth:0]   pos_sum;
   logic signed [PosWidth:0]   lim_pos;
   logic signed [PosWidth:0]   lim_neg;
   logic signed [PosWidth:0]   pos_clamp;

   always_comb begin
      now_phase = {phase_a, phase_b};
      step      = tqp_quarter_step({last_ff, now_phase});
      sub_sum   = {sub_ff[1], sub_ff} + {step[1], step};
      if (sub_sum >= StepFull) begin
         sub_adj = sub_sum - StepFull;
         delta   = 9'sd1;
      end else if (sub_sum <= -StepFull) begin
         sub_adj = sub_sum + StepFull;
         delta   = -9'sd1;
      end else begin
         sub_adj = sub_sum;
         delta   = 9'sd0;
      end
      pos_sum = {count_ff[PosWidth-1], count_ff} + delta;
      lim_pos = signed'({{(PosWidth+1-LimitWidth){1'b0}}, limit});
      lim_neg = -lim_pos;
      if (pos_sum > lim_pos) begin
         pos_clamp = lim_pos;
      end else if (pos_sum < lim_neg) begin
         pos_clamp = lim_neg;
      end else begin
         pos_clamp = pos_sum;
      end
      last_in  = now_phase;
      sub_in   = sub_adj[1:0];
      count_in = pos_clamp[PosWidth-1:0];
   end

   assign position = count_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff  <= '0;
         sub_ff   <= '0;
         count_ff <= '0;
      end else if (advance) begin
         last_ff  <= last_in;
         sub_ff   <= sub_in;
         count_ff <= count_in;
      end
   end

   a_sub_range: assert property (@(posedge clock) disable iff (reset)
      sub_ff != 2'b10)
      else $error("sub-count reached a full step without carry");

   a_hold_idle: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(count_ff) && $stable(last_ff))
      else $error("lane state moved without a transaction");

   a_count_sym: assert property (@(posedge clock) disable iff (reset)
      count_ff != 8'sh80)
      else $error("position reached the most negative code");

endmodule
`default_nettype wire

[src/tqp_out.sv]
// Result merge and output register with skid stage.
`default_nettype none
module tqp_out
   import tqp_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            push,
   input  wire tqp_result_type  push_data,
   output logic                 push_ready,
   output logic                 out_valid,
   input  wire logic            out_ready,
   output tqp_result_type       out_data
);

   logic           out_valid_ff, out_valid_in;
   logic           skid_valid_ff, skid_valid_in;
   tqp_result_type out_data_ff, out_data_in;
   tqp_result_type skid_data_ff, skid_data_in;
   logic           pop;

   assign pop        = out_valid_ff & out_ready;
   assign push_ready = !skid_valid_ff;
   assign out_valid  = out_valid_ff;
   assign out_data   = out_data_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || pop) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = push;
            skid_data_in  = push_data;
         end else begin
            out_valid_in = push;
            out_data_in  = push_data;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_data_in  = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held with empty output register");

   a_stall_fills_skid: assert property (@(posedge clock) disable iff (reset)
      (push && out_valid_ff && !out_ready) |=> skid_valid_ff)
      else $error("transaction lost while output stalled");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_ready) |=> out_valid_ff && $stable(out_data_ff))
      else $error("stalled result changed");

endmodule
`default_nettype wire

[dv/tb_two_axis_quadrature_position.sv]
`timescale 1ns / 100ps
// Testbench for the two-axis quadrature position decoder: pin sequences checked per transaction.
module tb_two_axis_quadrature_position;
   import tqp_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_x_phase_a = 1'b0;
   logic req_x_phase_b = 1'b0;
   logic req_y_phase_a = 1'b0;
   logic req_y_phase_b = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [PosWidth-1:0] rsp_x_position;
   logic signed [PosWidth-1:0] rsp_y_position;
   logic csr_write_enable = 1'b0;
   logic [LimitWidth-1:0] csr_write_data = '0;

   logic [LimitWidth-1:0] limit_setting = LimitReset;
   logic [1:0] last_x = 2'b00;
   logic [1:0] last_y = 2'b00;
   int sub_x = 0;
   int sub_y = 0;
   int pos_x = 0;
   int pos_y = 0;
   logic [1:0] drive_x = 2'b00;
   logic [1:0] drive_y = 2'b00;
   tqp_result_type pending_positions[$];
   int mismatch_count = 0;
   bit calm = 1'b0;
   int stall_request = 0;
   int stall_left = 0;

   two_axis_quadrature_position dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_x_phase_a(req_x_phase_a),
      .req_x_phase_b(req_x_phase_b),
      .req_y_phase_a(req_y_phase_a),
      .req_y_phase_b(req_y_phase_b),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_x_position(rsp_x_position),
      .rsp_y_position(rsp_y_position),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #3_000_000;
      $display("simulation failed");
      $finish;
   end

   always @(posedge clock) begin
      if (stall_request != 0) begin
         stall_left = stall_request;
         stall_request = 0;
      end
      if (stall_left != 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (calm) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= 16);
      end
   end

   always @(posedge clock) begin : check_result
      tqp_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_positions.size() == 0) begin
            $display("%0t unexpected transaction x %0d y %0d", $time, rsp_x_position,
                     rsp_y_position);
            mismatch_count++;
         end else begin
            want = pending_positions.pop_front();
            if (rsp_x_position !== want.x_position) begin
               $display("%0t x_position expected %0d actual %0d", $time, want.x_position,
                        rsp_x_position);
               mismatch_count++;
            end
            if (rsp_y_position !== want.y_position) begin
               $display("%0t y_position expected %0d actual %0d", $time, want.y_position,
                        rsp_y_position);
               mismatch_count++;
            end
         end
      end
   end

   // position of a phase in the forward cycle 00 -> 10 -> 11 -> 01
   function automatic logic [1:0] phase_order(input logic [1:0] pins);
      case (pins)
         2'b00: return 2'd0;
         2'b10: return 2'd1;
         2'b11: return 2'd2;
         default: return 2'd3;
      endcase
   endfunction

   function automatic logic [1:0] order_phase(input logic [1:0] order);
      case (order)
         2'd0: return 2'b00;
         2'd1: return 2'b10;
         2'd2: return 2'b11;
         default: return 2'b01;
      endcase
   endfunction

   function automatic int quarter_step(input logic [1:0] last, input logic [1:0] now);
      logic [1:0] turn;
      turn = phase_order(now) - phase_order(last);
      if (turn == 2'd1) return 1;
      if (turn == 2'd3) return -1;
      return 0;
   endfunction

   task automatic advance_axis(input logic [1:0] last, input logic [1:0] now, inout int sub,
                               inout int pos);
      int lim;
      lim = int'(limit_setting);
      sub += quarter_step(last, now);
      if (sub >= int'(StepFull)) begin
         pos++;
         sub -= int'(StepFull);
      end else if (sub <= -int'(StepFull)) begin
         pos--;
         sub += int'(StepFull);
      end
      if (pos > lim) begin
         pos = lim;
      end else if (pos < -lim) begin
         pos = -lim;
      end
   endtask

   task automatic track_sample(input logic [1:0] xp, input logic [1:0] yp);
      tqp_result_type want;
      advance_axis(last_x, xp, sub_x, pos_x);
      advance_axis(last_y, yp, sub_y, pos_y);
      last_x = xp;
      last_y = yp;
      want.x_position = PosWidth'(pos_x);
      want.y_position = PosWidth'(pos_y);
      pending_positions.push_back(want);
   endtask

   // mostly steps along dir, some holds, reversals and arbitrary jumps
   function automatic logic [1:0] next_phase(input logic [1:0] cur, input int dir);
      int roll;
      int way;
      roll = $urandom_range(0, 99);
      way = (dir != 0) ? dir : (($urandom_range(0, 1) == 1) ? 1 : -1);
      if (roll < 12) return 2'($urandom_range(0, 3));
      if (roll < 20) return cur;
      if (roll < 28) way = -way;
      return order_phase(phase_order(cur) + 2'(way));
   endfunction

   task automatic send_phases(input logic [1:0] xp, input logic [1:0] yp);
      if (!calm && $urandom_range(0, 99) < 11) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 2)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_x_phase_a <= xp[1];
      req_x_phase_b <= xp[0];
      req_y_phase_a <= yp[1];
      req_y_phase_b <= yp[0];
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      track_sample(xp, yp);
      drive_x = xp;
      drive_y = yp;
   endtask

   task automatic run_walk(input int count, input int x_dir, input int y_dir);
      repeat (count) send_phases(next_phase(drive_x, x_dir), next_phase(drive_y, y_dir));
   endtask

   task automatic step_both(input int count, input int x_dir, input int y_dir);
      repeat (count) begin
         send_phases(order_phase(phase_order(drive_x) + 2'(x_dir)),
                     order_phase(phase_order(drive_y) + 2'(y_dir)));
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_positions.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_limit(input logic [LimitWidth-1:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      limit_setting = value;
   endtask

   task automatic test_directed_patterns();
      logic [3:0] pattern[14];
      pattern = '{4'b0000, 4'b1111, 4'b0000,
                  4'b1001, 4'b1111, 4'b0110, 4'b0000, 4'b1001,
                  4'b1100, 4'b0000, 4'b1111, 4'b1111, 4'b0110, 4'b1001};
      foreach (pattern[i]) send_phases(pattern[i][3:2], pattern[i][1:0]);
   endtask

   task automatic test_full_range();
      int guard;
      wait_idle();
      write_limit(7'd127);
      guard = 0;
      while ((pos_x < 127 || pos_y > -127) && guard < 700) begin
         step_both(1, 1, -1);
         guard++;
      end
      step_both(10, 1, -1);
   endtask

   task automatic test_limit_changes();
      wait_idle();
      write_limit(7'd3);
      send_phases(drive_x, drive_y);
      step_both(4, 1, -1);
      wait_idle();
      write_limit(7'd0);
      step_both(6, 1, 1);
      send_phases(order_phase(phase_order(drive_x) + 2'd2), drive_y);
      step_both(3, -1, 0);
      wait_idle();
      write_limit(7'd2);
      run_walk(20, 0, 0);
   endtask

   task automatic test_output_stall();
      calm = 1'b1;
      stall_request = 50;
      run_walk(60, -1, 1);
      calm = 1'b0;
   endtask

   task automatic test_steady_stream();
      calm = 1'b1;
      run_walk(200, 0, 1);
      calm = 1'b0;
   endtask

   task automatic test_random_limits();
      int limits[7];
      int done;
      int count;
      limits = '{int'(LimitReset), 1, 127, 42, 85, 64, 0};
      limits[6] = $urandom_range(2, 126);
      foreach (limits[i]) begin
         wait_idle();
         write_limit(LimitWidth'(limits[i]));
         done = 0;
         while (done < 120) begin
            count = $urandom_range(20, 80);
            run_walk(count, int'($urandom_range(0, 2)) - 1, int'($urandom_range(0, 2)) - 1);
            done += count;
         end
      end
   endtask

   initial begin
      int drain;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_patterns();
      test_full_range();
      test_limit_changes();
      test_output_stall();
      test_steady_stream();
      test_random_limits();
      req_valid <= 1'b0;
      drain = 0;
      while (pending_positions.size() != 0 && drain < 1000) begin
         @(posedge clock);
         drain++;
      end
      repeat (4) @(posedge clock);
      if (mismatch_count == 0 && pending_positions.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
